>>> hdl/rhash_pkg.sv
// ----------------------------------------------------------------------------
// rhash_pkg
// Shared types, codes, constants and helper functions of the ray hit
// annular sector histogram block.
// ----------------------------------------------------------------------------
package rhash_pkg;

    localparam logic [1:0] CMD_RAY    = 2'd0;
    localparam logic [1:0] CMD_READ_R = 2'd1;
    localparam logic [1:0] CMD_READ_A = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE      = 3'd5;

    localparam int DIV_STEPS    = 40;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = 6;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [4:0]         bin_index;
    } rhash_in_t;

    typedef struct packed {
        logic               skipped;
        logic               hit;
        logic [4:0]         radius_bin;
        logic [3:0]         angle_bin;
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic [31:0]        bin_count;
    } rhash_out_t;

    typedef struct packed {
        logic              load;
        logic              div_step;
        logic              proj;
        logic              offs;
        logic              sq1;
        logic              sq2;
        logic              sqrt_step;
        logic              cordic_step;
        logic              judge;
        logic              bdiv_init_r;
        logic              bdiv_init_a;
        logic              bdiv_step;
        logic              bdiv_done_r;
        logic              bdiv_done_a;
        logic              mem_rd;
        logic              mem_upd;
        logic              clear;
        logic              finish;
        logic [STEP_W-1:0] step;
    } rhash_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       dz_zero;
        logic       hit;
    } rhash_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -42'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [35:0] shr_tz(input logic signed [35:0] v,
                                                  input logic [4:0] s);
        logic signed [35:0] r;
        if (v[35])
        begin
            r = -((-v) >>> s);
        end
        else
        begin
            r = v >>> s;
        end
        return r;
    endfunction

    function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
        logic signed [19:0] r;
        unique case (i)
            5'd0:    r = 20'sd51472;
            5'd1:    r = 20'sd30386;
            5'd2:    r = 20'sd16055;
            5'd3:    r = 20'sd8150;
            5'd4:    r = 20'sd4091;
            5'd5:    r = 20'sd2047;
            5'd6:    r = 20'sd1024;
            5'd7:    r = 20'sd512;
            5'd8:    r = 20'sd256;
            5'd9:    r = 20'sd128;
            5'd10:   r = 20'sd64;
            5'd11:   r = 20'sd32;
            5'd12:   r = 20'sd16;
            5'd13:   r = 20'sd8;
            5'd14:   r = 20'sd4;
            5'd15:   r = 20'sd2;
            5'd16:   r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/rhash_in_if.sv
// ----------------------------------------------------------------------------
// rhash_in_if
// Input channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface rhash_in_if;
    import rhash_pkg::*;

    logic      valid;
    logic      ready;
    rhash_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rhash_out_if.sv
// ----------------------------------------------------------------------------
// rhash_out_if
// Output channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface rhash_out_if;
    import rhash_pkg::*;

    logic       valid;
    logic       ready;
    rhash_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rhash_ctrl.sv
// ----------------------------------------------------------------------------
// rhash_ctrl
// Sequencer: steps the datapath through projection, radius, angle, binning
// and histogram access, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module rhash_ctrl #(
    parameter int QUOT_BITS = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  rhash_pkg::rhash_sts_t sts,
    output rhash_pkg::rhash_cmd_t cmd
);
    import rhash_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_PROJ    = 5'd3;
    localparam logic [4:0] S_OFFS    = 5'd4;
    localparam logic [4:0] S_SQ1     = 5'd5;
    localparam logic [4:0] S_SQ2     = 5'd6;
    localparam logic [4:0] S_SQRT    = 5'd7;
    localparam logic [4:0] S_JUDGE   = 5'd8;
    localparam logic [4:0] S_BINIT_R = 5'd9;
    localparam logic [4:0] S_BDIV_R  = 5'd10;
    localparam logic [4:0] S_BINIT_A = 5'd11;
    localparam logic [4:0] S_BDIV_A  = 5'd12;
    localparam logic [4:0] S_BFIN_A  = 5'd13;
    localparam logic [4:0] S_RD      = 5'd14;
    localparam logic [4:0] S_WR      = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    logic [4:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.step   = cnt_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.command)
                    CMD_RAY:
                    begin
                        cnt_next   = '0;
                        state_next = sts.dz_zero ? S_DONE : S_DIV;
                    end
                    CMD_READ_R, CMD_READ_A:
                    begin
                        state_next = S_RD;
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_PROJ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = S_OFFS;
            end
            S_OFFS:
            begin
                cmd.offs   = 1'b1;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.sq1    = 1'b1;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.sq2    = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step   = 1'b1;
                cmd.cordic_step = (cnt_reg < STEP_W'(CORDIC_STEPS));
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_JUDGE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_JUDGE:
            begin
                cmd.judge  = 1'b1;
                state_next = S_BINIT_R;
            end
            S_BINIT_R:
            begin
                if (sts.hit)
                begin
                    cmd.bdiv_init_r = 1'b1;
                    cnt_next        = STEP_W'(QUOT_BITS - 1);
                    state_next      = S_BDIV_R;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BDIV_R:
            begin
                cmd.bdiv_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_BINIT_A;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_BINIT_A:
            begin
                cmd.bdiv_done_r = 1'b1;
                cmd.bdiv_init_a = 1'b1;
                cnt_next        = STEP_W'(QUOT_BITS - 1);
                state_next      = S_BDIV_A;
            end
            S_BDIV_A:
            begin
                cmd.bdiv_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_BFIN_A;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_BFIN_A:
            begin
                cmd.bdiv_done_a = 1'b1;
                state_next      = S_RD;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.mem_upd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/rhash_dp.sv
// ----------------------------------------------------------------------------
// rhash_dp
// Datapath: configuration registers, projection divider, square root,
// CORDIC angle unit, bin divider, histogram memories and result register.
// ----------------------------------------------------------------------------
module rhash_dp #(
    parameter int RADIUS_CHANNELS = 16,
    parameter int ANGLE_CHANNELS  = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rhash_pkg::rhash_cmd_t          cmd,
    output rhash_pkg::rhash_sts_t          sts,
    input  logic                           cfg_we,
    input  logic [rhash_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  rhash_pkg::rhash_in_t           in_data,
    output rhash_pkg::rhash_out_t          out_data
);
    import rhash_pkg::*;

    localparam int RAW  = $clog2(RADIUS_CHANNELS + 1);
    localparam int AAW  = $clog2(ANGLE_CHANNELS + 1);
    localparam int MAXC = (RADIUS_CHANNELS > ANGLE_CHANNELS) ? RADIUS_CHANNELS
                                                             : ANGLE_CHANNELS;
    localparam int QW   = $clog2(MAXC + 2);
    localparam int DNW  = 32 + QW;

    // configuration
    logic [23:0]        pd_reg;
    logic signed [31:0] co_reg;
    logic [31:0]        minr_reg;
    logic [31:0]        maxr_reg;
    logic signed [15:0] mina_reg;
    logic signed [15:0] maxa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pd_reg   <= 24'd4096;
            co_reg   <= '0;
            minr_reg <= '0;
            maxr_reg <= 32'd4096;
            mina_reg <= -16'sd12868;
            maxa_reg <= 16'sd12868;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLANE_DISTANCE: pd_reg   <= cfg_data[23:0];
                CFG_CENTER_OFFSET:  co_reg   <= cfg_data;
                CFG_MIN_RADIUS:     minr_reg <= cfg_data;
                CFG_MAX_RADIUS:     maxr_reg <= cfg_data;
                CFG_MIN_ANGLE:      mina_reg <= cfg_data[15:0];
                CFG_MAX_ANGLE:      maxa_reg <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // item registers
    logic [1:0]         cmd_reg;
    logic [4:0]         idx_reg;
    logic               dz_zero_reg;
    logic               sx_reg, sy_reg;
    logic [15:0]        mz_reg;
    logic [39:0]        nx_reg, ny_reg;
    logic [15:0]        rx_reg, ry_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               xneg_reg, yneg_reg;
    logic [63:0]        sqa_reg;
    logic [63:0]        sn_reg, sres_reg, sbit_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic               hit_reg, aok_reg;
    logic [31:0]        off_reg, rd_reg;
    logic [15:0]        aoff_reg, ad_reg;
    logic [DNW-1:0]     bnum_reg;
    logic [31:0]        bden_reg;
    logic [QW-1:0]      bq_reg;
    logic [RAW-1:0]     rbin_reg;
    logic [AAW-1:0]     abin_reg;
    logic [31:0]        count_reg;
    rhash_out_t         out_reg;

    // load
    logic signed [40:0] prod_x, prod_y;
    logic [39:0]        mag_x, mag_y;
    assign prod_x = 41'(in_data.dir_x) * 41'(signed'({1'b0, pd_reg}));
    assign prod_y = 41'(in_data.dir_y) * 41'(signed'({1'b0, pd_reg}));
    assign mag_x  = prod_x[40] ? 40'(-prod_x) : prod_x[39:0];
    assign mag_y  = prod_y[40] ? 40'(-prod_y) : prod_y[39:0];

    // projection divider, one quotient bit per step
    logic [16:0] tx, ty;
    logic        gex, gey;
    assign tx  = {rx_reg, nx_reg[39]};
    assign ty  = {ry_reg, ny_reg[39]};
    assign gex = (tx >= {1'b0, mz_reg});
    assign gey = (ty >= {1'b0, mz_reg});

    // projection and centre shift
    logic signed [31:0] px_next, py_next, xr;
    assign px_next = sat32(sx_reg ? -42'(signed'({1'b0, nx_reg}))
                                  :  42'(signed'({1'b0, nx_reg})));
    assign py_next = sat32(sy_reg ? -42'(signed'({1'b0, ny_reg}))
                                  :  42'(signed'({1'b0, ny_reg})));
    assign xr      = sat32(42'(px_reg) - 42'(co_reg));

    // squares, shared multiplier
    logic [31:0] mul_src;
    logic [63:0] sq_prod;
    assign mul_src = cmd.sq1 ? ax_reg : ay_reg;
    assign sq_prod = {32'd0, mul_src} * {32'd0, mul_src};

    // square root step
    logic [63:0] s_try;
    assign s_try = sres_reg + sbit_reg;

    // CORDIC step
    logic [4:0]         ci;
    logic signed [35:0] xs, ys;
    logic signed [19:0] at;
    assign ci = cmd.step[4:0];
    assign xs = shr_tz(cx_reg, ci);
    assign ys = shr_tz(cy_reg, ci);
    assign at = atan_q16(ci);

    // angle and window test
    logic signed [19:0] zc, zq;
    logic signed [15:0] mag, ang;
    logic               ang_ok, hit_next;
    logic [31:0]        r;
    logic signed [16:0] ad, aoff;
    always_comb
    begin
        zc  = cz_reg[19] ? 20'sd0 : cz_reg;
        zq  = (zc + 20'sd4) >>> 3;
        mag = (zq > 20'(HALF_PI_Q13)) ? HALF_PI_Q13 : zq[15:0];
        ang_ok = 1'b1;
        if (ay_reg == '0)
        begin
            ang_ok = (ax_reg != '0);
            ang    = '0;
        end
        else if (ax_reg == '0)
        begin
            ang = yneg_reg ? -HALF_PI_Q13 : HALF_PI_Q13;
        end
        else
        begin
            ang = (yneg_reg ^ xneg_reg) ? -mag : mag;
        end
        r        = sres_reg[31:0];
        hit_next = ang_ok && (r <= maxr_reg) && (r > minr_reg)
                   && (ang <= maxa_reg) && (ang > mina_reg);
        ad       = 17'(maxa_reg) - 17'(mina_reg);
        aoff     = 17'(ang) + 17'(maxa_reg);
    end

    // bin divider step, quotient bit k
    logic [DNW-1:0] bsub;
    assign bsub = DNW'(bden_reg) << cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= in_data.command;
            idx_reg     <= in_data.bin_index;
            dz_zero_reg <= (in_data.dir_z == '0);
            sx_reg      <= in_data.dir_x[15] ^ in_data.dir_z[15];
            sy_reg      <= in_data.dir_y[15] ^ in_data.dir_z[15];
            mz_reg      <= in_data.dir_z[15] ? 16'(-in_data.dir_z) : in_data.dir_z;
            nx_reg      <= mag_x;
            ny_reg      <= mag_y;
            rx_reg      <= '0;
            ry_reg      <= '0;
            hit_reg     <= 1'b0;
        end
        if (cmd.div_step)
        begin
            rx_reg <= gex ? 16'(tx - {1'b0, mz_reg}) : tx[15:0];
            ry_reg <= gey ? 16'(ty - {1'b0, mz_reg}) : ty[15:0];
            nx_reg <= {nx_reg[38:0], gex};
            ny_reg <= {ny_reg[38:0], gey};
        end
        if (cmd.proj)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.offs)
        begin
            ax_reg   <= xr[31] ? 32'(-33'(xr)) : 32'(xr);
            ay_reg   <= py_reg[31] ? 32'(-33'(py_reg)) : 32'(py_reg);
            xneg_reg <= xr[31];
            yneg_reg <= py_reg[31];
        end
        if (cmd.sq1)
        begin
            sqa_reg <= sq_prod;
        end
        if (cmd.sq2)
        begin
            sn_reg   <= sqa_reg + sq_prod;
            sres_reg <= '0;
            sbit_reg <= 64'd1 << 62;
            cx_reg   <= 36'(ax_reg);
            cy_reg   <= 36'(ay_reg);
            cz_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            if (sn_reg >= s_try)
            begin
                sn_reg   <= sn_reg - s_try;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.cordic_step)
        begin
            if (!cy_reg[35])
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
        end
        if (cmd.judge)
        begin
            hit_reg  <= hit_next;
            off_reg  <= r - minr_reg;
            rd_reg   <= maxr_reg - minr_reg;
            aok_reg  <= (aoff > 17'sd0) && (aoff <= ad);
            aoff_reg <= aoff[15:0];
            ad_reg   <= ad[15:0];
        end
        if (cmd.bdiv_init_r)
        begin
            bnum_reg <= DNW'(off_reg) * DNW'(RADIUS_CHANNELS) + DNW'(rd_reg)
                        - DNW'(1);
            bden_reg <= rd_reg;
            bq_reg   <= '0;
        end
        if (cmd.bdiv_init_a)
        begin
            bnum_reg <= DNW'(aoff_reg) * DNW'(ANGLE_CHANNELS) + DNW'(ad_reg)
                        - DNW'(1);
            bden_reg <= 32'(ad_reg);
            bq_reg   <= '0;
        end
        if (cmd.bdiv_step && (bnum_reg >= bsub))
        begin
            bnum_reg <= bnum_reg - bsub;
            bq_reg   <= bq_reg | (QW'(1) << cmd.step);
        end
        if (cmd.bdiv_done_r)
        begin
            if ((32'(bq_reg) - 32'd1) > 32'(RADIUS_CHANNELS))
            begin
                rbin_reg <= RAW'(RADIUS_CHANNELS);
            end
            else
            begin
                rbin_reg <= RAW'(bq_reg - 1'b1);
            end
        end
        if (cmd.bdiv_done_a)
        begin
            abin_reg <= aok_reg ? AAW'(bq_reg - 1'b1) : AAW'(ANGLE_CHANNELS);
        end
    end

    // histogram memories with valid bits
    logic [31:0]             rhist_mem [RADIUS_CHANNELS+1];
    logic [31:0]             ahist_mem [ANGLE_CHANNELS+1];
    logic [RADIUS_CHANNELS:0] rvld_reg;
    logic [ANGLE_CHANNELS:0]  avld_reg;
    logic [31:0]             rdat_reg, adat_reg;
    logic                    rvrd_reg, avrd_reg;
    logic [RAW-1:0]          r_addr;
    logic [AAW-1:0]          a_addr;
    logic                    ray, r_inrange, a_inrange, bump;
    logic [31:0]             r_cur, a_cur;

    assign ray       = (cmd_reg == CMD_RAY);
    assign r_inrange = (32'(idx_reg) <= 32'(RADIUS_CHANNELS));
    assign a_inrange = (32'(idx_reg) <= 32'(ANGLE_CHANNELS));
    assign r_addr    = ray ? rbin_reg : RAW'(idx_reg);
    assign a_addr    = ray ? abin_reg : AAW'(idx_reg);
    assign r_cur     = rvrd_reg ? rdat_reg : 32'd0;
    assign a_cur     = avrd_reg ? adat_reg : 32'd0;
    assign bump      = cmd.mem_upd && ray && hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd && (ray || r_inrange))
        begin
            rdat_reg <= rhist_mem[r_addr];
            rvrd_reg <= rvld_reg[r_addr];
        end
        if (cmd.mem_rd && (ray || a_inrange))
        begin
            adat_reg <= ahist_mem[a_addr];
            avrd_reg <= avld_reg[a_addr];
        end
        if (bump)
        begin
            rhist_mem[rbin_reg] <= (r_cur == '1) ? r_cur : r_cur + 32'd1;
            ahist_mem[abin_reg] <= (a_cur == '1) ? a_cur : a_cur + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= '0;
            avld_reg <= '0;
        end
        else if (cmd.clear)
        begin
            rvld_reg <= '0;
            avld_reg <= '0;
        end
        else if (bump)
        begin
            rvld_reg[rbin_reg] <= 1'b1;
            avld_reg[abin_reg] <= 1'b1;
        end
    end

    // result word
    logic projected, hit_out;
    assign projected = ray && !dz_zero_reg;
    assign hit_out   = projected && hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_upd)
        begin
            if (cmd_reg == CMD_READ_R)
            begin
                count_reg <= r_inrange ? r_cur : 32'd0;
            end
            else
            begin
                count_reg <= a_inrange ? a_cur : 32'd0;
            end
        end
        if (cmd.finish)
        begin
            out_reg.skipped    <= ray && dz_zero_reg;
            out_reg.hit        <= hit_out;
            out_reg.radius_bin <= hit_out ? 5'(rbin_reg) : 5'(RADIUS_CHANNELS);
            out_reg.angle_bin  <= hit_out ? 4'(abin_reg) : 4'(ANGLE_CHANNELS);
            out_reg.plane_x    <= projected ? px_reg : 32'sd0;
            out_reg.plane_y    <= projected ? py_reg : 32'sd0;
            out_reg.bin_count  <= ((cmd_reg == CMD_READ_R) || (cmd_reg == CMD_READ_A))
                                  ? count_reg : 32'd0;
        end
    end

    assign out_data    = out_reg;
    assign sts.command = cmd_reg;
    assign sts.dz_zero = dz_zero_reg;
    assign sts.hit     = hit_reg;

endmodule

>>> hdl/ray_hit_annular_sector_histogram_top.sv
// ----------------------------------------------------------------------------
// ray_hit_annular_sector_histogram_top
// Ray projection, annular sector hit test and saturating radius and angle
// histograms with read and clear commands.
// ----------------------------------------------------------------------------
// One word is processed at a time. A ray word passes through the 40-step
// projection divider and the 32-step square root (the 17-step CORDIC runs
// beside it); a ray that hits the window then runs the bit-serial bin
// divider once per histogram, with Q = clog2(max(RADIUS_CHANNELS,
// ANGLE_CHANNELS) + 2) quotient bits each. Read commands, clear and
// zero-dz rays skip the arithmetic. A new word is accepted while the
// previous result still waits on the output.
// ----------------------------------------------------------------------------
module ray_hit_annular_sector_histogram_top #(
    parameter int RADIUS_CHANNELS = 16,
    parameter int ANGLE_CHANNELS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rhash_in_if.sink                        in_ch,
    rhash_out_if.source                     out_ch,
    input  logic                            cfg_we,
    input  logic [rhash_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import rhash_pkg::*;

    localparam int MAXC = (RADIUS_CHANNELS > ANGLE_CHANNELS) ? RADIUS_CHANNELS
                                                             : ANGLE_CHANNELS;
    localparam int QW   = $clog2(MAXC + 2);

    rhash_cmd_t cmd;
    rhash_sts_t sts;

    rhash_ctrl #(
        .QUOT_BITS (QW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rhash_dp #(
        .RADIUS_CHANNELS (RADIUS_CHANNELS),
        .ANGLE_CHANNELS  (ANGLE_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_ch.data),
        .out_data  (out_ch.data)
    );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray hit annular sector histogram block. Drives
// directed and random command words under several register settings, holds
// a bit-true predictor of projection, radius, CORDIC angle, binning and the
// saturating histograms, and compares every result word field by field.
// ----------------------------------------------------------------------------
class ray_hist_model;
    localparam int NR = 16;
    localparam int NA = 8;

    logic [23:0]        plane_dist;
    logic signed [31:0] ctr_off;
    logic [31:0]        r_lo;
    logic [31:0]        r_hi;
    logic signed [15:0] a_lo;
    logic signed [15:0] a_hi;
    bit [31:0]          radius_hist[NR+1];
    bit [31:0]          angle_hist[NA+1];
    rhash_pkg::rhash_out_t pending_results[$];
    int                 mismatches;

    function void reset_state();
        plane_dist = 24'd4096;
        ctr_off    = 0;
        r_lo       = 0;
        r_hi       = 32'd4096;
        a_lo       = -16'sd12868;
        a_hi       = 16'sd12868;
        foreach (radius_hist[i]) radius_hist[i] = 0;
        foreach (angle_hist[i]) angle_hist[i] = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            rhash_pkg::CFG_PLANE_DISTANCE: plane_dist = v[23:0];
            rhash_pkg::CFG_CENTER_OFFSET:  ctr_off    = v;
            rhash_pkg::CFG_MIN_RADIUS:     r_lo       = v;
            rhash_pkg::CFG_MAX_RADIUS:     r_hi       = v;
            rhash_pkg::CFG_MIN_ANGLE:      a_lo       = v[15:0];
            rhash_pkg::CFG_MAX_ANGLE:      a_hi       = v[15:0];
            default: ;
        endcase
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint trunc_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function longint cordic_angle(longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint tbl[17];
        tbl = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2, 1};
        x = a;
        y = b;
        z = 0;
        for (int i = 0; i < 17; i++)
        begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + tbl[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - tbl[i];
            end
        end
        if (z < 0) z = 0;
        z = (z + 4) >>> 3;
        if (z > 12868) z = 12868;
        return z;
    endfunction

    function rhash_pkg::rhash_out_t project_ray(rhash_pkg::rhash_in_t w);
        rhash_pkg::rhash_out_t r;
        longint dx, dy, dz, d, px, py, xr, ang, amin, amax, ad, aoff, c;
        longint unsigned ax, ay, rad, rd, off, rbin;
        int abin;
        bit ang_ok;
        r = '0;
        rbin = NR;
        abin = NA;
        if (w.command == rhash_pkg::CMD_RAY)
        begin
            if (w.dir_z == 0)
            begin
                r.skipped = 1'b1;
            end
            else
            begin
                dx = w.dir_x;
                dy = w.dir_y;
                dz = w.dir_z;
                d  = longint'({40'd0, plane_dist});
                px = clip32((dx * d) / dz);
                py = clip32((dy * d) / dz);
                xr = clip32(px - longint'(ctr_off));
                ax = (xr < 0) ? -xr : xr;
                ay = (py < 0) ? -py : py;
                rad = int_sqrt(ax * ax + ay * ay);
                ang_ok = 1;
                if (ay == 0)
                begin
                    ang_ok = (ax != 0);
                    ang = 0;
                end
                else if (ax == 0)
                begin
                    ang = (py < 0) ? -12868 : 12868;
                end
                else
                begin
                    ang = cordic_angle(ax, ay);
                    if ((py < 0) != (xr < 0)) ang = -ang;
                end
                amin = a_lo;
                amax = a_hi;
                if (ang_ok && rad <= {32'd0, r_hi} && rad > {32'd0, r_lo} &&
                    ang <= amax && ang > amin)
                begin
                    rd   = {32'd0, r_hi} - {32'd0, r_lo};
                    off  = rad - {32'd0, r_lo};
                    ad   = amax - amin;
                    aoff = ang + amax;
                    r.hit = 1'b1;
                    rbin = (off * NR + rd - 1) / rd - 1;
                    if (rbin > NR) rbin = NR;
                    if (aoff > 0)
                    begin
                        c = (aoff * NA + ad - 1) / ad - 1;
                        if (c < NA) abin = int'(c);
                    end
                    if (radius_hist[rbin] != 32'hFFFFFFFF)
                        radius_hist[rbin]++;
                    if (angle_hist[abin] != 32'hFFFFFFFF)
                        angle_hist[abin]++;
                end
                r.plane_x = px[31:0];
                r.plane_y = py[31:0];
            end
        end
        else if (w.command == rhash_pkg::CMD_READ_R)
        begin
            if (w.bin_index <= NR) r.bin_count = radius_hist[w.bin_index];
        end
        else if (w.command == rhash_pkg::CMD_READ_A)
        begin
            if (w.bin_index <= NA) r.bin_count = angle_hist[w.bin_index];
        end
        else
        begin
            foreach (radius_hist[i]) radius_hist[i] = 0;
            foreach (angle_hist[i]) angle_hist[i] = 0;
        end
        r.radius_bin = rbin[4:0];
        r.angle_bin  = abin[3:0];
        return r;
    endfunction

    function void note_word(rhash_pkg::rhash_in_t w);
        pending_results = {pending_results, project_ray(w)};
    endfunction

    function void check_word(rhash_pkg::rhash_out_t got);
        rhash_pkg::rhash_out_t e;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing pending: %h", got);
            mismatches++;
            return;
        end
        e = pending_results.pop_front();
        if (got.skipped !== e.skipped)
        begin
            $error("skipped: expected %0d, got %0d", e.skipped, got.skipped);
            mismatches++;
        end
        if (got.hit !== e.hit)
        begin
            $error("hit: expected %0d, got %0d", e.hit, got.hit);
            mismatches++;
        end
        if (got.radius_bin !== e.radius_bin)
        begin
            $error("radius_bin: expected %0d, got %0d", e.radius_bin, got.radius_bin);
            mismatches++;
        end
        if (got.angle_bin !== e.angle_bin)
        begin
            $error("angle_bin: expected %0d, got %0d", e.angle_bin, got.angle_bin);
            mismatches++;
        end
        if (got.plane_x !== e.plane_x)
        begin
            $error("plane_x: expected %0d, got %0d", e.plane_x, got.plane_x);
            mismatches++;
        end
        if (got.plane_y !== e.plane_y)
        begin
            $error("plane_y: expected %0d, got %0d", e.plane_y, got.plane_y);
            mismatches++;
        end
        if (got.bin_count !== e.bin_count)
        begin
            $error("bin_count: expected %0d, got %0d", e.bin_count, got.bin_count);
            mismatches++;
        end
    endfunction
endclass

module tb;
    import rhash_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          snd_idle;
    int          rcv_idle;
    int          hold_req;
    int          hold_left;
    longint      cycles;
    ray_hist_model model;

    rhash_in_if  in_ch ();
    rhash_out_if out_ch ();

    ray_hit_annular_sector_histogram_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1500000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            model.note_word(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
            model.check_word(out_ch.data);
    end

    task automatic send_word(rhash_in_t w);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic ray(int dx, int dy, int dz);
        rhash_in_t w;
        w.command   = CMD_RAY;
        w.dir_x     = 16'(dx);
        w.dir_y     = 16'(dy);
        w.dir_z     = 16'(dz);
        w.bin_index = 5'($urandom);
        send_word(w);
    endtask

    task automatic cmd_word(logic [1:0] c, int idx);
        rhash_in_t w;
        w.command   = c;
        w.dir_x     = 16'($urandom);
        w.dir_y     = 16'($urandom);
        w.dir_z     = 16'($urandom);
        w.bin_index = 5'(idx);
        send_word(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        model.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (model.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic load_setting(int ph);
        logic [31:0] s[6];
        case (ph)
            0: s = '{4096, 0, 0, 4096, -12868, 12868};
            1: s = '{24'hFFFFFF, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, -32768, 32767};
            2: s = '{0, 32'h80000000, 100, 200, -12868, 12868};
            3: s = '{1000, 500, 50, 3000, -6000, 9000};
            4: s = '{65536, -20000, 1000, 32'hFFFFFFFF, 0, 12868};
            default: s = '{2048, 300, 4000, 10, 12868, -12868};
        endcase
        for (int i = 0; i < 6; i++) write_reg(i[2:0], s[i]);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int roll;
        int dz;
        roll = $urandom_range(99);
        if (roll < 72)
        begin
            dz = ($urandom_range(99) < 4) ? 0 : -int'($urandom_range(32768, 1));
            ray(int'($signed(16'($urandom))) >>> $urandom_range(15),
                int'($signed(16'($urandom))) >>> $urandom_range(15), dz);
        end
        else if (roll < 85)
            cmd_word(CMD_READ_R, $urandom_range(16));
        else if (roll < 97)
            cmd_word(CMD_READ_A, $urandom_range(16));
        else
            cmd_word(CMD_CLEAR, $urandom_range(16));
    endtask

    initial
    begin
        model = new();
        model.reset_state();
        cycles       = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        snd_idle     = 36;
        rcv_idle     = 88;
        hold_req     = 0;
        hold_left    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ray(1000, 1000, 0);
        ray(0, 0, -32768);
        ray(0, 1000, -32768);
        ray(0, -1000, -32768);
        ray(1000, 0, -32768);
        ray(-1000, 0, -20000);
        ray(-32768, 32767, -1);
        ray(32767, -32768, -1);
        ray(300, 200, -16384);
        ray(-300, 200, -16384);
        ray(-300, -200, -16384);
        ray(300, -200, -16384);
        ray(5, 8000, -9000);
        cmd_word(CMD_READ_R, 0);
        cmd_word(CMD_READ_R, 16);
        cmd_word(CMD_READ_A, 0);
        cmd_word(CMD_READ_A, 8);
        cmd_word(CMD_READ_A, 12);
        cmd_word(CMD_READ_R, 5);
        cmd_word(CMD_CLEAR, 0);
        cmd_word(CMD_READ_A, 3);
        ray(300, 200, -16384);
        cmd_word(CMD_READ_R, 31);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            load_setting(ph);
            snd_idle = (ph < 2) ? 36 : (ph < 4) ? 88 : 0;
            rcv_idle = (ph < 2) ? 88 : (ph < 4) ? 36 : 0;
            if (ph == 4) hold_req = 800;
            for (int n = 0; n < 205; n++) random_word();
        end
        wait_drained();
        repeat (120) @(posedge clk);
        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
